// File: sv/isodir_pkg.sv
// isodir_pkg: shared constants and the entry result type of the directory record parser
// used by isodir_core, isodir_obuf and iso9660_dir_record_parser; no dependencies

package isodir_pkg;

	// default geometry
	localparam int DEF_SECTOR_BYTES = 2048;
	localparam int DEF_OFFSET_BITS  = 24;

	// identifier characters
	localparam logic [7:0] CHAR_SEMI = 8'h3B;
	localparam logic [7:0] CHAR_DOT  = 8'h2E;

	// record byte positions
	localparam logic [7:0] POS_SECTOR_LO = 8'd2;
	localparam logic [7:0] POS_SECTOR_HI = 8'd5;
	localparam logic [7:0] POS_LENGTH_LO = 8'd10;
	localparam logic [7:0] POS_LENGTH_HI = 8'd13;
	localparam logic [7:0] POS_DATE_LO   = 8'd18;
	localparam logic [7:0] POS_DATE_HI   = 8'd23;
	localparam logic [7:0] POS_FLAGS     = 8'd25;
	localparam logic [7:0] POS_ID_LEN    = 8'd32;
	localparam logic [7:0] POS_NAME      = 8'd33;

	localparam int          DIR_FLAG_BIT = 1;
	localparam logic [11:0] YEAR_BASE    = 12'd1900;

	// result bus width, packed without gaps and padded to bytes
	localparam int RESULT_BITS = 181;
	localparam int TDATA_BITS  = ((RESULT_BITS + 7) / 8) * 8;

	typedef struct packed {
		logic [7:0]  second;
		logic [7:0]  minute;
		logic [7:0]  hour;
		logic [7:0]  day;
		logic [7:0]  month;
		logic [11:0] year;
		logic [7:0]  name_length;
		logic [23:0] name_offset;
		logic        is_directory;
		logic [31:0] data_length;
		logic [31:0] start_address;
		logic [31:0] node_id;
	} entry_t;

endpackage

// File: sv/isodir_core.sv
// isodir_core: per-byte record state, field capture and entry formation
// depends on isodir_pkg

module isodir_core #(
	parameter int SECTOR_BYTES = isodir_pkg::DEF_SECTOR_BYTES,
	parameter int OFFSET_BITS  = isodir_pkg::DEF_OFFSET_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           data_byte,
	input  logic                 last_byte,
	output logic                 emit,
	output isodir_pkg::entry_t   entry
);

	localparam int SW = (SECTOR_BYTES > 1) ? $clog2(SECTOR_BYTES) : 1;
	localparam int NW = (OFFSET_BITS > 24) ? OFFSET_BITS : 24;
	localparam logic [SW-1:0] SEC_LAST = SW'(SECTOR_BYTES - 1);

	logic [OFFSET_BITS-1:0] off_q;
	logic [SW-1:0]          sec_q;
	logic [7:0]             pos_q;
	logic [7:0]             rlen_q;
	logic                   pad_q;
	logic [31:0]            ext_sec_q;
	logic [31:0]            ext_len_q;
	logic                   dir_q;
	logic [7:0]             idlen_q;
	logic [47:0]            date_q;
	logic [7:0]             first_q;
	logic [7:0]             semi_q;
	logic                   dotsemi_q;
	logic                   prevdot_q;
	logic [31:0]            node_q;

	logic                   pad_clr, pad_now, at_start, rec_start, in_rec, finish, drop;
	logic [31:0]            c_ext_sec, c_ext_len;
	logic                   c_dir;
	logic [7:0]             c_idlen, c_first, c_semi;
	logic [47:0]            c_date;
	logic                   c_dotsemi, c_prevdot;
	logic [1:0]             idx_sec, idx_len;
	logic [2:0]             idx_date;
	logic [7:0]             name_i;
	logic [7:0]             rl_eff, avail, eff, name_len;
	logic [OFFSET_BITS-1:0] off_inc, name_off;
	logic [NW-1:0]          name_off_ext;
	logic [7:0]             pos_d;
	logic                   pad_d;
	logic [SW-1:0]          sec_d;

	// padding and record phase of this byte
	assign pad_clr   = pad_q && (sec_q == '0);
	assign pad_now   = pad_q && !pad_clr;
	assign at_start  = !pad_now && (pos_q == 8'd0);
	assign rec_start = at_start && (data_byte != 8'd0);
	assign in_rec    = !pad_now && (pos_q != 8'd0);

	assign idx_sec  = 2'(pos_q - isodir_pkg::POS_SECTOR_LO);
	assign idx_len  = 2'(pos_q - isodir_pkg::POS_LENGTH_LO);
	assign idx_date = 3'(pos_q - isodir_pkg::POS_DATE_LO);
	assign name_i   = pos_q - isodir_pkg::POS_NAME;

	// field capture, cleared at each record start
	always_comb begin
		c_ext_sec = rec_start ? '0 : ext_sec_q;
		c_ext_len = rec_start ? '0 : ext_len_q;
		c_dir     = rec_start ? 1'b0 : dir_q;
		c_idlen   = rec_start ? '0 : idlen_q;
		c_date    = rec_start ? '0 : date_q;
		c_first   = rec_start ? '0 : first_q;
		c_semi    = rec_start ? '0 : semi_q;
		c_dotsemi = rec_start ? 1'b0 : dotsemi_q;
		c_prevdot = rec_start ? 1'b0 : prevdot_q;
		if (in_rec) begin
			if (pos_q >= isodir_pkg::POS_SECTOR_LO && pos_q <= isodir_pkg::POS_SECTOR_HI) begin
				c_ext_sec[8*idx_sec +: 8] = data_byte;
			end else if (pos_q >= isodir_pkg::POS_LENGTH_LO &&
					pos_q <= isodir_pkg::POS_LENGTH_HI) begin
				c_ext_len[8*idx_len +: 8] = data_byte;
			end else if (pos_q >= isodir_pkg::POS_DATE_LO && pos_q <= isodir_pkg::POS_DATE_HI) begin
				c_date[8*idx_date +: 8] = data_byte;
			end else if (pos_q == isodir_pkg::POS_FLAGS) begin
				c_dir = data_byte[isodir_pkg::DIR_FLAG_BIT];
			end else if (pos_q == isodir_pkg::POS_ID_LEN) begin
				c_idlen = data_byte;
			end else if (pos_q >= isodir_pkg::POS_NAME && name_i < idlen_q) begin
				if (name_i == 8'd0) begin
					c_first = data_byte;
				end
				if (data_byte == isodir_pkg::CHAR_SEMI) begin
					c_semi    = name_i + 8'd1;
					c_dotsemi = (name_i != 8'd0) && prevdot_q;
				end
				c_prevdot = (data_byte == isodir_pkg::CHAR_DOT);
			end
		end
	end

	// record completion and name trimming
	assign rl_eff = rec_start ? data_byte : rlen_q;
	assign finish = (rec_start && data_byte == 8'd1) ||
		(in_rec && ({1'b0, pos_q} + 9'd1 == {1'b0, rlen_q}));
	assign avail  = (rl_eff > isodir_pkg::POS_NAME) ? rl_eff - isodir_pkg::POS_NAME : 8'd0;
	assign eff    = (c_idlen < avail) ? c_idlen : avail;
	assign drop   = (eff == 8'd1) && (c_first <= 8'd1);
	assign emit   = accept && finish && !drop;

	always_comb begin
		name_len = eff;
		if (!c_dir && c_semi != 8'd0) begin
			name_len = c_semi - 8'd1 - {7'd0, c_dotsemi};
		end
	end

	// identifier offset: record start plus the fixed header size
	assign name_off     = off_q - OFFSET_BITS'(rl_eff) + OFFSET_BITS'(34);
	assign name_off_ext = NW'(name_off);

	always_comb begin
		entry.node_id       = node_q;
		entry.start_address = 32'(c_ext_sec * 32'(SECTOR_BYTES));
		entry.data_length   = c_ext_len;
		entry.is_directory  = c_dir;
		entry.name_offset   = name_off_ext[23:0];
		entry.name_length   = name_len;
		entry.year          = {4'd0, c_date[7:0]} + isodir_pkg::YEAR_BASE;
		entry.month         = c_date[15:8];
		entry.day           = c_date[23:16];
		entry.hour          = c_date[31:24];
		entry.minute        = c_date[39:32];
		entry.second        = c_date[47:40];
	end

	// next position, padding and offset tracking
	assign off_inc = off_q + OFFSET_BITS'(1);

	always_comb begin
		if (last_byte || finish) begin
			pos_d = 8'd0;
		end else if (rec_start) begin
			pos_d = 8'd1;
		end else if (in_rec) begin
			pos_d = pos_q + 8'd1;
		end else begin
			pos_d = pos_q;
		end
		if (last_byte) begin
			pad_d = 1'b0;
		end else if (at_start && data_byte == 8'd0) begin
			pad_d = 1'b1;
		end else if (pad_clr) begin
			pad_d = 1'b0;
		end else begin
			pad_d = pad_q;
		end
		if (last_byte || off_inc == '0 || sec_q == SEC_LAST) begin
			sec_d = '0;
		end else begin
			sec_d = sec_q + SW'(1);
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q  <= '0;
			sec_q  <= '0;
			pos_q  <= '0;
			rlen_q <= '0;
			pad_q  <= 1'b0;
			node_q <= '0;
		end else if (accept) begin
			off_q  <= last_byte ? '0 : off_inc;
			sec_q  <= sec_d;
			pos_q  <= pos_d;
			rlen_q <= rl_eff;
			pad_q  <= pad_d;
			if (emit) begin
				node_q <= node_q + 32'd1;
			end
		end
	end

	// captured record fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_sec_q <= '0;
			ext_len_q <= '0;
			dir_q     <= 1'b0;
			idlen_q   <= '0;
			date_q    <= '0;
			first_q   <= '0;
			semi_q    <= '0;
			dotsemi_q <= 1'b0;
			prevdot_q <= 1'b0;
		end else if (accept) begin
			ext_sec_q <= c_ext_sec;
			ext_len_q <= c_ext_len;
			dir_q     <= c_dir;
			idlen_q   <= c_idlen;
			date_q    <= c_date;
			first_q   <= c_first;
			semi_q    <= c_semi;
			dotsemi_q <= c_dotsemi;
			prevdot_q <= c_prevdot;
		end
	end

endmodule

// File: sv/isodir_obuf.sv
// isodir_obuf: result register with a skid stage for the entry stream
// depends on isodir_pkg

module isodir_obuf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  isodir_pkg::entry_t push_data,
	output logic               space,
	output logic               out_valid,
	input  logic               out_ready,
	output isodir_pkg::entry_t out_data
);

	logic               main_v_q, skid_v_q;
	isodir_pkg::entry_t main_d_q, skid_d_q;

	assign space     = !skid_v_q;
	assign out_valid = main_v_q;
	assign out_data  = main_d_q;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!main_v_q || out_ready) begin
			main_v_q <= skid_v_q || push;
			skid_v_q <= 1'b0;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (!main_v_q || out_ready) begin
			main_d_q <= skid_v_q ? skid_d_q : push_data;
		end else if (push) begin
			skid_d_q <= push_data;
		end
	end

endmodule

// File: sv/iso9660_dir_record_parser.sv
// Directory record parser: takes one byte of directory extent data per beat and emits
// one entry beat per completed record other than '.' and '..'. A byte is taken every
// cycle while the output side keeps up; an entry is formed from the record state and
// its last byte, then registered in the output register, or in the skid while stalled.
// A two-entry result buffer (output register plus skid) keeps input flowing while the
// output stalls until a second entry is waiting; s_tready then stays low until the
// output register is taken, and is high again in the cycle after that entry beat.
// Sector padding is skipped by tracking the offset within the sector; no clearing
// pass is needed after reset.
// depends on isodir_pkg, isodir_core, isodir_obuf

module iso9660_dir_record_parser #(
	parameter int SECTOR_BYTES = isodir_pkg::DEF_SECTOR_BYTES,
	parameter int OFFSET_BITS  = isodir_pkg::DEF_OFFSET_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,   // [7:0] data_byte
	input  logic                              s_tlast,   // last_byte
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [31:0] node_id, [63:32] start_address, [95:64] data_length, [96] is_directory,
	// [120:97] name_offset, [128:121] name_length, [140:129] year, [148:141] month,
	// [156:149] day, [164:157] hour, [172:165] minute, [180:173] second, rest zero
	output logic [isodir_pkg::TDATA_BITS-1:0] m_tdata
);

	logic               accept, emit, space;
	isodir_pkg::entry_t entry, out_entry;

	assign s_tready = space;
	assign accept   = s_tvalid && space;

	// byte parsing
	isodir_core #(
		.SECTOR_BYTES(SECTOR_BYTES),
		.OFFSET_BITS (OFFSET_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.data_byte(s_tdata),
		.last_byte(s_tlast),
		.emit     (emit),
		.entry    (entry)
	);

	// entry output buffering
	isodir_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (emit),
		.push_data(entry),
		.space    (space),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (out_entry)
	);

	assign m_tdata = isodir_pkg::TDATA_BITS'(out_entry);

endmodule

// File: sim/iso9660_dir_record_parser_chk.sv
// Checker for the directory record parser: watches the byte and entry channels,
// predicts each entry from the accepted bytes and compares every field in order
// depends on isodir_pkg

module iso9660_dir_record_parser_chk (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	input  logic [7:0]                        s_tdata,   // [7:0] data_byte
	input  logic                              s_tlast,   // last_byte
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic [isodir_pkg::TDATA_BITS-1:0] m_tdata,   // entry_t fields, node_id lowest
	output int                                mismatches,
	output int                                entries_waiting
);

	import isodir_pkg::*;

	// parser state as the block should hold it
	logic [23:0] dir_pos;
	logic [7:0]  rec_pos;
	logic [7:0]  rec_len;
	logic        skipping;
	logic [31:0] ext_sector;
	logic [31:0] ext_len;
	logic        dir_bit;
	logic [7:0]  id_len;
	logic [47:0] stamp;
	logic [7:0]  first_ch;
	logic [7:0]  semi_at;
	logic        dot_semi;
	logic        last_dot;
	logic [31:0] next_node;

	entry_t entry_q[$];
	int     errors;

	task automatic clear_fields();
		ext_sector = '0;
		ext_len    = '0;
		dir_bit    = 1'b0;
		id_len     = '0;
		stamp      = '0;
		first_ch   = '0;
		semi_at    = '0;
		dot_semi   = 1'b0;
		last_dot   = 1'b0;
	endtask

	// record complete: queue an entry unless it is '.' or '..'
	task automatic close_record(input logic [23:0] at);
		logic [7:0]  avail;
		logic [7:0]  eff;
		logic [7:0]  nlen;
		logic [23:0] rec_base;
		entry_t      e;
		avail   = (rec_len > POS_NAME) ? rec_len - POS_NAME : 8'd0;
		eff     = (id_len < avail) ? id_len : avail;
		nlen    = eff;
		rec_pos = '0;
		if (!(eff == 8'd1 && first_ch <= 8'd1)) begin
			// files lose the version suffix and a dot right before it
			if (!dir_bit && semi_at != 8'd0)
				nlen = semi_at - 8'd1 - {7'd0, dot_semi};
			rec_base        = at - {16'd0, rec_len} + 24'd1;
			e.node_id       = next_node;
			e.start_address = ext_sector * 32'(DEF_SECTOR_BYTES);
			e.data_length   = ext_len;
			e.is_directory  = dir_bit;
			e.name_offset   = rec_base + {16'd0, POS_NAME};
			e.name_length   = nlen;
			e.year          = {4'd0, stamp[7:0]} + YEAR_BASE;
			e.month         = stamp[15:8];
			e.day           = stamp[23:16];
			e.hour          = stamp[31:24];
			e.minute        = stamp[39:32];
			e.second        = stamp[47:40];
			entry_q.push_back(e);
			next_node = next_node + 32'd1;
		end
	endtask

	// one accepted byte through the parser
	task automatic parse_byte(input logic [7:0] b, input logic l);
		logic [23:0] at;
		logic [7:0]  i;
		at = dir_pos;
		if (skipping && (32'(at) % 32'(DEF_SECTOR_BYTES)) == 0)
			skipping = 1'b0;
		if (skipping) begin
			// inside sector padding
		end else if (rec_pos == 8'd0) begin
			if (b == 8'd0) begin
				skipping = 1'b1;
			end else begin
				rec_len = b;
				clear_fields();
				if (b == 8'd1)
					close_record(at);
				else
					rec_pos = 8'd1;
			end
		end else begin
			// field capture by position in the record
			if (rec_pos >= POS_SECTOR_LO && rec_pos <= POS_SECTOR_HI) begin
				ext_sector = ext_sector | (32'(b) << (8 * (rec_pos - POS_SECTOR_LO)));
			end else if (rec_pos >= POS_LENGTH_LO && rec_pos <= POS_LENGTH_HI) begin
				ext_len = ext_len | (32'(b) << (8 * (rec_pos - POS_LENGTH_LO)));
			end else if (rec_pos >= POS_DATE_LO && rec_pos <= POS_DATE_HI) begin
				stamp = stamp | (48'(b) << (8 * (rec_pos - POS_DATE_LO)));
			end else if (rec_pos == POS_FLAGS) begin
				dir_bit = b[DIR_FLAG_BIT];
			end else if (rec_pos == POS_ID_LEN) begin
				id_len = b;
			end else if (rec_pos >= POS_NAME) begin
				i = rec_pos - POS_NAME;
				if (i < id_len) begin
					if (i == 8'd0)
						first_ch = b;
					if (b == CHAR_SEMI) begin
						semi_at  = i + 8'd1;
						dot_semi = (i > 8'd0) && last_dot;
					end
					last_dot = (b == CHAR_DOT);
				end
			end
			if (rec_pos + 8'd1 == rec_len)
				close_record(at);
			else
				rec_pos = rec_pos + 8'd1;
		end
		// end of directory returns to offset zero, node numbers carry on
		if (l) begin
			dir_pos  = '0;
			rec_pos  = '0;
			skipping = 1'b0;
		end else begin
			dir_pos = at + 24'd1;
		end
	endtask

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h got %h", $time, what, want, got);
			errors++;
		end
	endtask

	// compare entry beats first, then advance the prediction with the byte beat
	always @(posedge clk or negedge arst_n) begin : monitor
		entry_t seen;
		entry_t want;
		if (!arst_n) begin
			dir_pos   = '0;
			rec_pos   = '0;
			rec_len   = '0;
			skipping  = 1'b0;
			next_node = '0;
			clear_fields();
			entry_q.delete();
			errors = 0;
			mismatches      <= 0;
			entries_waiting <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen = m_tdata[RESULT_BITS-1:0];
				if (entry_q.size() == 0) begin
					$display("%0t: entry beat expected none got %h", $time, m_tdata);
					errors++;
				end else begin
					want = entry_q.pop_front();
					check_field("node_id", want.node_id, seen.node_id);
					check_field("start_address", want.start_address, seen.start_address);
					check_field("data_length", want.data_length, seen.data_length);
					check_field("is_directory", 32'(want.is_directory),
						32'(seen.is_directory));
					check_field("name_offset", 32'(want.name_offset),
						32'(seen.name_offset));
					check_field("name_length", 32'(want.name_length),
						32'(seen.name_length));
					check_field("year", 32'(want.year), 32'(seen.year));
					check_field("month", 32'(want.month), 32'(seen.month));
					check_field("day", 32'(want.day), 32'(seen.day));
					check_field("hour", 32'(want.hour), 32'(seen.hour));
					check_field("minute", 32'(want.minute), 32'(seen.minute));
					check_field("second", 32'(want.second), 32'(seen.second));
					check_field("tdata padding", 32'd0,
						32'(m_tdata[TDATA_BITS-1:RESULT_BITS]));
				end
			end
			if (s_tvalid && s_tready)
				parse_byte(s_tdata, s_tlast);
			mismatches      <= errors;
			entries_waiting <= entry_q.size();
		end
	end

endmodule

// File: sim/iso9660_dir_record_parser_tb.sv
// Testbench top for the directory record parser: builds directory extents of
// directed and random records, drives the byte channel and paces the entry channel
// depends on isodir_pkg, iso9660_dir_record_parser, iso9660_dir_record_parser_chk

module iso9660_dir_record_parser_tb;

	import isodir_pkg::*;

	localparam int HOLD_CYCLES  = 300;
	localparam int QUIET_LIMIT  = 3000;
	localparam int ITEM_TARGET  = 1500;
	localparam int CALM_ITEMS   = 300;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [7:0]            s_tdata;
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [TDATA_BITS-1:0] m_tdata;
	int                    mismatches;
	int                    entries_waiting;

	// stimulus bookkeeping
	logic [7:0] rec_img [256];
	logic [7:0] dir_q[$];
	int         items_sent   = 0;
	int         gap_pct      = 0;
	int         stall_pct    = 0;
	int         holds_asked  = 0;
	int         holds_done   = 0;
	int         quiet        = 0;
	logic       calm         = 1'b0;

	always #4 clk = ~clk;

	iso9660_dir_record_parser DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	iso9660_dir_record_parser_chk checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.mismatches(mismatches),
		.entries_waiting(entries_waiting)
	);

	function automatic logic [7:0] pick_char();
		case ($urandom_range(0, 9))
			0: return CHAR_SEMI;
			1: return CHAR_DOT;
			2: return 8'($urandom);
			3: return 8'h30 + 8'($urandom_range(0, 9));
			default: return 8'h41 + 8'($urandom_range(0, 25));
		endcase
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 3))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic put_le(input int pos, input logic [31:0] value);
		for (int k = 0; k < 4; k++)
			rec_img[pos + k] = value[8*k +: 8];
	endtask

	// random record image with the given kind and identifier length
	task automatic new_record(input logic dir_flag, input int id_len);
		for (int i = 0; i < 256; i++)
			rec_img[i] = 8'($urandom);
		put_le(POS_SECTOR_LO, rand_word());
		put_le(POS_LENGTH_LO, rand_word());
		rec_img[POS_FLAGS][DIR_FLAG_BIT] = dir_flag;
		rec_img[POS_ID_LEN] = 8'(id_len);
		for (int i = 0; i < id_len && POS_NAME + i < 256; i++)
			rec_img[POS_NAME + i] = pick_char();
	endtask

	task automatic put_name(input string s);
		rec_img[POS_ID_LEN] = 8'(s.len());
		for (int i = 0; i < s.len(); i++)
			rec_img[POS_NAME + i] = s[i];
	endtask

	task automatic emit_record(input int rlen);
		rec_img[0] = 8'(rlen);
		for (int i = 0; i < rlen; i++)
			dir_q.push_back(rec_img[i]);
	endtask

	// drive the queued directory as byte beats, tlast on the final one
	task automatic send_dir();
		for (int i = 0; i < dir_q.size(); i++) begin
			if ($urandom_range(0, 99) < gap_pct) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= dir_q[i];
			s_tlast  <= (i == dir_q.size() - 1);
			do @(posedge clk); while (!s_tready);
			items_sent++;
		end
		dir_q.delete();
	endtask

	// one directory of mostly well-formed records with random content
	task automatic random_dir();
		int n_rec;
		int kind;
		int idl;
		int rlen;
		if (!calm) begin
			gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : 10 * $urandom_range(1, 4);
			stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 10 * $urandom_range(1, 4);
		end
		n_rec  = $urandom_range(1, 8);
		for (int r = 0; r < n_rec; r++) begin
			kind = $urandom_range(0, 19);
			if (kind < 10) begin
				// well-formed file or directory, often with a version suffix
				idl = $urandom_range(1, 14);
				new_record($urandom_range(0, 3) == 0, idl);
				if (idl >= 3 && $urandom_range(0, 1) == 0) begin
					rec_img[POS_NAME + idl - 2] = CHAR_SEMI;
					rec_img[POS_NAME + idl - 1] = 8'h31;
					if ($urandom_range(0, 1) == 0)
						rec_img[POS_NAME + idl - 3] = CHAR_DOT;
				end
				rlen = POS_NAME + idl + $urandom_range(0, 3);
			end else if (kind == 10) begin
				// self or parent entry
				new_record(1'b1, 1);
				rec_img[POS_NAME] = 8'($urandom_range(0, 1));
				rlen = POS_NAME + 1;
			end else if (kind < 14) begin
				// record shorter than its fields
				new_record($urandom_range(0, 1), $urandom_range(0, 20));
				rlen = $urandom_range(1, 40);
			end else if (kind < 16) begin
				// identifier running past the record end
				idl = $urandom_range(2, 60);
				new_record($urandom_range(0, 1), idl);
				rlen = POS_NAME + $urandom_range(0, idl - 1);
			end else if (kind == 16) begin
				idl = $urandom_range(100, 222);
				new_record($urandom_range(0, 1), idl);
				rlen = POS_NAME + idl;
			end else begin
				// noise record
				new_record($urandom_range(0, 1), $urandom_range(0, 255));
				rlen = $urandom_range(1, 255);
			end
			emit_record((rlen > 255) ? 255 : rlen);
		end
		case ($urandom_range(0, 9))
			// directory cut off inside a record
			0: repeat ($urandom_range(1, 10))
				if (dir_q.size() > 1)
					void'(dir_q.pop_back());
			// directory ends inside sector padding
			1: begin
				dir_q.push_back(8'h00);
				repeat ($urandom_range(1, 20)) dir_q.push_back(8'($urandom));
			end
			default: ;
		endcase
		send_dir();
	endtask

	// receiver pacing with random stalls and one long hold-off
	initial begin
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (holds_done != holds_asked) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done = holds_asked;
			end else if ($urandom_range(0, 99) < stall_pct) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = 8'h00;
		s_tlast  = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		gap_pct   = 20;
		stall_pct = 20;

		// directed: self and parent entries
		new_record(1'b1, 1); rec_img[POS_NAME] = 8'h00; emit_record(34);
		new_record(1'b1, 1); rec_img[POS_NAME] = 8'h01; emit_record(34);
		// sector, length and date at their top values, directory flag clear
		new_record(1'b0, 0);
		put_le(POS_SECTOR_LO, 32'hFFFF_FFFF);
		put_le(POS_LENGTH_LO, 32'hFFFF_FFFF);
		for (int i = POS_DATE_LO; i <= POS_DATE_HI; i++) rec_img[i] = 8'hFF;
		rec_img[POS_FLAGS] = 8'hFD;
		put_name("README.TXT;1"); emit_record(46);
		// sector, length and date zero, a two byte name of zeros is kept
		new_record(1'b1, 2);
		put_le(POS_SECTOR_LO, 32'h0);
		put_le(POS_LENGTH_LO, 32'h0);
		for (int i = POS_DATE_LO; i <= POS_DATE_HI; i++) rec_img[i] = 8'h00;
		rec_img[POS_FLAGS]    = 8'h02;
		rec_img[POS_NAME]     = 8'h00;
		rec_img[POS_NAME + 1] = 8'h00;
		emit_record(36);
		// name trimming cases
		new_record(1'b0, 0); put_name("A.;1");      emit_record(38);
		new_record(1'b0, 0); put_name("NOVERSION"); emit_record(43);
		new_record(1'b1, 0); put_name("SUB;1");     emit_record(38);
		new_record(1'b0, 0); put_name(";");         emit_record(34);
		new_record(1'b0, 0); put_name("A;1;2");     emit_record(38);
		new_record(1'b0, 0); put_name(".;1");       emit_record(36);
		new_record(1'b0, 0); put_name("A.B;1");     emit_record(38);
		// parent name on a file record is dropped too
		new_record(1'b0, 1); rec_img[POS_NAME] = 8'h01; emit_record(34);
		// record of length one, then short records
		emit_record(1);
		new_record(1'b0, 8); emit_record(20);
		new_record(1'b1, 8); emit_record(26);
		new_record(1'b0, 8); emit_record(33);
		// identifier overrun, once cut down to a lone zero byte
		new_record(1'b0, 10); emit_record(38);
		new_record(1'b0, 5); rec_img[POS_NAME] = 8'h00; emit_record(34);
		// longest record
		new_record(1'b0, 222); emit_record(255);
		// a record ending exactly on the last byte
		new_record(1'b0, 0); put_name("END.DAT;1"); emit_record(42);
		send_dir();
		// record cut off by the end of the directory
		new_record(1'b1, 0); put_name("NEXT"); emit_record(37);
		new_record(1'b0, 0); put_name("CUT.BIN;1"); emit_record(42);
		repeat (5) void'(dir_q.pop_back());
		send_dir();
		// directory ending inside padding
		new_record(1'b0, 0); put_name("PAD.X;1"); emit_record(40);
		dir_q.push_back(8'h00);
		repeat (10) dir_q.push_back(8'($urandom));
		send_dir();

		// back pressure: dense entries while the receiver holds off
		gap_pct = 0;
		holds_asked++;
		repeat (64) emit_record(1);
		send_dir();

		// random directories
		while (items_sent < ITEM_TARGET - CALM_ITEMS)
			random_dir();

		// closing stretch without idling
		calm      = 1'b1;
		gap_pct   = 0;
		stall_pct = 0;
		do random_dir(); while (items_sent < ITEM_TARGET);
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (entries_waiting != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
